// ===== rtl/core/pid_controller_step_macros.svh =====
// Assertion macros for the PID controller step block.
`ifndef PID_CONTROLLER_STEP_MACROS_SVH
`define PID_CONTROLLER_STEP_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define PCS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Implication whose consequent is checked in the cycle after the antecedent.
`define PCS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ===== rtl/core/pcs_pkg.sv =====
// Package with types, constants and helpers of the PID controller step block.
package pcs_pkg;
  localparam int unsigned FracBitsDefault = 16;
  localparam bit DirectActingDefault = 1'b1;

  typedef enum logic [1:0] {
    CMD_UPDATE  = 2'd0,
    CMD_RESET   = 2'd1,
    CMD_ENABLE  = 2'd2,
    CMD_DISABLE = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    REG_GAIN_P  = 3'd0,
    REG_GAIN_I  = 3'd1,
    REG_GAIN_D  = 3'd2,
    REG_OUT_MIN = 3'd3,
    REG_OUT_MAX = 3'd4,
    REG_INT_MIN = 3'd5,
    REG_INT_MAX = 3'd6,
    REG_PERIOD  = 3'd7
  } reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_P,
    ST_MUL_I,
    ST_MUL_D,
    ST_INC_A,
    ST_INC_B,
    ST_DIV_D,
    ST_SUM,
    ST_DONE
  } state_e;

  // Datapath operation requested by the controller.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_CMD,
    OP_MUL_P,
    OP_MUL_I,
    OP_MUL_D,
    OP_INC_A,
    OP_INC_B,
    OP_DIV_D,
    OP_SUM
  } op_e;

  typedef struct packed {
    op_e  op;
    logic start;
  } ctrl_t;

  typedef struct packed {
    logic busy;
    logic compute;
    logic dt_zero;
  } stat_t;

  typedef struct packed {
    logic [31:0] gain_p;
    logic [31:0] gain_i;
    logic [31:0] gain_d;
    logic [31:0] output_min;
    logic [31:0] output_max;
    logic [31:0] integral_min;
    logic [31:0] integral_max;
    logic [15:0] sample_period_ms;
  } cfg_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) return 32'sh7fffffff;
    if (v < -66'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] clamp32(input logic signed [31:0] v,
      input logic signed [31:0] lo, input logic signed [31:0] hi);
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction
endpackage

// ===== rtl/core/pcs_if.sv =====
// Valid/ready channel interfaces of the PID controller step block.
interface pcs_in_if (input logic clk_i);
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [31:0] measurement;
  logic [31:0] target;
  logic [31:0] now_ms;
  modport source (output valid, command, measurement, target, now_ms, input ready);
  modport sink (input valid, command, measurement, target, now_ms, output ready);
endinterface

interface pcs_out_if (input logic clk_i);
  logic        valid;
  logic        ready;
  logic [31:0] drive;
  logic [31:0] p_part;
  logic [31:0] i_part;
  logic [31:0] d_part;
  logic [31:0] error_value;
  logic        computed;
  logic        active;
  modport source (output valid, drive, p_part, i_part, d_part, error_value, computed,
    active, input ready);
  modport sink (input valid, drive, p_part, i_part, d_part, error_value, computed,
    active, output ready);
endinterface

interface pcs_cfg_if (input logic clk_i);
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/core/pcs_ctrl.sv =====
// Controller state machine that sequences one item through the datapath.
module pcs_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_fire_i,
  input  logic           out_free_i,
  input  pcs_pkg::stat_t stat_i,
  output pcs_pkg::ctrl_t ctrl_o,
  output logic           idle_o,
  output logic           done_o
);
  import pcs_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_fire_i) state_d = ST_MUL_P;
      ST_MUL_P: state_d = stat_i.compute ? ST_MUL_I : ST_DONE;
      ST_MUL_I: state_d = ST_MUL_D;
      ST_MUL_D: state_d = ST_INC_A;
      ST_INC_A: state_d = ST_INC_B;
      ST_INC_B: state_d = stat_i.dt_zero ? ST_SUM : ST_DIV_D;
      ST_DIV_D: if (!stat_i.busy) state_d = ST_SUM;
      ST_SUM:   state_d = ST_DONE;
      ST_DONE:  if (out_free_i) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl_o = '{op: OP_NONE, start: 1'b0};
    idle_o = 1'b0;
    done_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        idle_o = 1'b1;
        if (in_fire_i) ctrl_o.op = OP_LOAD;
      end
      ST_MUL_P: ctrl_o.op = stat_i.compute ? OP_MUL_P : OP_CMD;
      ST_MUL_I: ctrl_o.op = OP_MUL_I;
      ST_MUL_D: ctrl_o.op = OP_MUL_D;
      ST_INC_A: begin
        ctrl_o.op = OP_INC_A;
        ctrl_o.start = !stat_i.dt_zero;
      end
      ST_INC_B: ctrl_o.op = OP_INC_B;
      ST_DIV_D: ctrl_o.op = OP_DIV_D;
      ST_SUM:   ctrl_o.op = OP_SUM;
      ST_DONE:  done_o = 1'b1;
      default:  ctrl_o.op = OP_NONE;
    endcase
  end
endmodule

// ===== rtl/core/pcs_div.sv =====
// Restoring divider, one quotient bit per cycle, truncating toward zero.
module pcs_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [63:0] num_i,
  input  logic [31:0]        den_i,
  output logic               busy_o,
  output logic signed [63:0] quo_o
);
  logic [63:0] rem_q, rem_d, quo_q, quo_d;
  logic [31:0] den_q;
  logic        neg_q;
  logic [6:0]  cnt_q;
  logic [64:0] trial;
  logic [63:0] mag;

  assign mag = num_i[63] ? 64'(-num_i) : num_i;
  assign trial = {rem_q, quo_q[63]} - {33'd0, den_q};

  always_comb begin
    rem_d = {rem_q[62:0], quo_q[63]};
    quo_d = {quo_q[62:0], 1'b0};
    if (!trial[64]) begin
      rem_d = trial[63:0];
      quo_d[0] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= 7'd64;
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - 7'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= mag;
      den_q <= den_i;
      neg_q <= num_i[63];
    end else if (cnt_q != '0) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign busy_o = (cnt_q != '0);
  assign quo_o = neg_q ? -$signed(quo_q) : $signed(quo_q);
endmodule

// ===== rtl/core/pcs_dp.sv =====
// Datapath with state registers, multiplier, divider and saturation logic.
module pcs_dp #(
  parameter int unsigned FRAC_BITS = pcs_pkg::FracBitsDefault,
  parameter bit DIRECT_ACTING = pcs_pkg::DirectActingDefault
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  pcs_pkg::ctrl_t ctrl_i,
  input  pcs_pkg::cfg_t  cfg_i,
  input  logic [1:0]     command_i,
  input  logic [31:0]    measurement_i,
  input  logic [31:0]    target_i,
  input  logic [31:0]    now_ms_i,
  output pcs_pkg::stat_t stat_o,
  output logic [31:0]    drive_o,
  output logic [31:0]    p_part_o,
  output logic [31:0]    i_part_o,
  output logic [31:0]    d_part_o,
  output logic [31:0]    error_value_o,
  output logic           computed_o,
  output logic           active_o
);
  import pcs_pkg::*;

  // floor(x / 1000) equals (x * Recip1000) >> RecipShift for any x below 2^32.
  localparam logic [63:0] Recip1000 = 64'd274877907;
  localparam int unsigned RecipShift = 38;

  logic               active_q;
  logic signed [31:0] integ_q, prev_q, drive_q, p_q, i_q, d_q, err_q;
  logic [31:0]        last_q;
  logic               computed_q;
  logic [1:0]         cmd_q;
  logic signed [31:0] meas_q, tgt_q, err_w;
  logic [31:0]        now_q, dt_q;
  logic signed [31:0] p_t_q, kie_q, m_q, acc_q, dterm_q;
  logic signed [31:0] mul_a, mul_b, qm;
  logic signed [63:0] prod;
  logic signed [63:0] prod_sh;
  logic               div_start, div_busy;
  logic signed [63:0] div_num, div_quo;
  logic [31:0]        div_den;
  logic signed [31:0] acc_new, sum_w;
  logic signed [31:0] p_o, i_o, d_o, s_o;
  logic [22:0]        dtq_q;
  logic [9:0]         dtr_q;
  logic [31:0]        kmag_q;
  logic               kneg_q;
  logic [21:0]        kq_q;
  logic [63:0]        pa_q;
  logic [31:0]        pb_q;
  logic [19:0]        eb_q;
  logic [63:0]        dt_rcp, kmag_rcp, eb_rcp, inc_mag;
  logic [31:0]        dt_rem, kmag_w, k_rem;
  logic signed [63:0] inc_w;

  // Error is recomputed from the held item; stable for the whole item.
  assign err_w = sat32(66'(meas_q) * 0 + 66'(tgt_q) - 66'(meas_q));

  always_comb begin
    mul_a = cfg_i.gain_p;
    mul_b = err_w;
    if (ctrl_i.op == OP_MUL_I) mul_a = cfg_i.gain_i;
    if (ctrl_i.op == OP_MUL_D) begin
      mul_a = cfg_i.gain_d;
      mul_b = sat32(66'(meas_q) - 66'(prev_q));
    end
  end
  assign prod = 64'(mul_a) * 64'(mul_b);
  assign prod_sh = prod >>> FRAC_BITS;
  assign qm = sat32(prod_sh[63] ? {2'b11, prod_sh} : {2'b00, prod_sh});

  // The integral step Ki*err*dt/1000 is split as dt = 1000*a + b and
  // |Ki*err| = 1000*c + e, so that only small reciprocal multiplies are needed:
  // |Ki*err|*a + c*b + floor(e*b/1000), with the sign of Ki*err put back.
  assign dt_rcp = ({32'd0, dt_q} * Recip1000) >> RecipShift;
  assign dt_rem = dt_q - ({9'd0, dtq_q} * 32'd1000);
  assign kmag_w = kie_q[31] ? (~kie_q + 32'd1) : kie_q;
  assign kmag_rcp = ({32'd0, kmag_w} * Recip1000) >> RecipShift;
  assign k_rem = kmag_q - ({10'd0, kq_q} * 32'd1000);
  assign eb_rcp = ({44'd0, eb_q} * Recip1000) >> RecipShift;
  assign inc_mag = pa_q + {32'd0, pb_q} + eb_rcp;
  assign inc_w = kneg_q ? -$signed(inc_mag) : $signed(inc_mag);

  assign div_start = ctrl_i.start;
  assign div_num = 64'(m_q) * 64'sd1000;
  assign div_den = dt_q;

  pcs_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (div_den),
    .busy_o (div_busy),
    .quo_o  (div_quo)
  );

  assign acc_new = clamp32(sat32(66'(integ_q) + 66'(inc_w)), cfg_i.integral_min,
    cfg_i.integral_max);
  assign sum_w = sat32(66'(p_t_q) + 66'(acc_q) - 66'(dterm_q));
  assign p_o = DIRECT_ACTING ? p_t_q : sat32(-66'(p_t_q));
  assign i_o = DIRECT_ACTING ? acc_q : sat32(-66'(acc_q));
  assign d_o = DIRECT_ACTING ? dterm_q : sat32(-66'(dterm_q));
  assign s_o = DIRECT_ACTING ? sum_w : sat32(-66'(sum_w));

  assign stat_o.busy = div_busy;
  assign stat_o.dt_zero = (dt_q == '0);
  assign stat_o.compute = (cmd_q == CMD_UPDATE) && active_q &&
    (dt_q >= {16'd0, cfg_i.sample_period_ms});

  always_ff @(posedge clk_i) begin
    unique case (ctrl_i.op)
      OP_LOAD: begin
        cmd_q  <= command_i;
        meas_q <= measurement_i;
        tgt_q  <= target_i;
        now_q  <= now_ms_i;
        dt_q   <= now_ms_i - last_q;
      end
      OP_MUL_P: begin
        p_t_q <= qm;
        dtq_q <= dt_rcp[22:0];
      end
      OP_MUL_I: begin
        kie_q <= qm;
        dtr_q <= dt_rem[9:0];
      end
      OP_MUL_D: begin
        m_q     <= qm;
        dterm_q <= '0;
        kmag_q  <= kmag_w;
        kneg_q  <= kie_q[31];
        kq_q    <= kmag_rcp[21:0];
      end
      OP_INC_A: begin
        pa_q <= {32'd0, kmag_q} * {41'd0, dtq_q};
        pb_q <= {10'd0, kq_q} * {22'd0, dtr_q};
        eb_q <= k_rem[9:0] * dtr_q;
      end
      OP_INC_B: acc_q <= acc_new;
      OP_DIV_D: if (!div_busy) dterm_q <= sat32(div_quo[63] ? {2'b11, div_quo} :
        {2'b00, div_quo});
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      integ_q <= '0;
      prev_q <= '0;
      last_q <= '0;
      drive_q <= '0;
      p_q <= '0;
      i_q <= '0;
      d_q <= '0;
      err_q <= '0;
      computed_q <= 1'b0;
    end else begin
      if (ctrl_i.op == OP_LOAD) computed_q <= 1'b0;
      if (ctrl_i.op == OP_CMD) begin
        unique case (cmd_e'(cmd_q))
          CMD_RESET: begin
            integ_q <= '0;
            prev_q <= '0;
            last_q <= now_q;
            {drive_q, p_q, i_q, d_q, err_q} <= '0;
          end
          CMD_ENABLE: begin
            active_q <= 1'b1;
            last_q <= now_q;
          end
          CMD_DISABLE: begin
            active_q <= 1'b0;
            drive_q <= '0;
          end
          CMD_UPDATE: if (!active_q) {drive_q, p_q, i_q, d_q, err_q} <= '0;
          default: ;
        endcase
      end
      if (ctrl_i.op == OP_SUM) begin
        integ_q <= acc_q;
        drive_q <= clamp32(s_o, cfg_i.output_min, cfg_i.output_max);
        p_q <= p_o;
        i_q <= i_o;
        d_q <= d_o;
        err_q <= err_w;
        prev_q <= meas_q;
        last_q <= now_q;
        computed_q <= 1'b1;
      end
    end
  end

  assign drive_o = drive_q;
  assign p_part_o = p_q;
  assign i_part_o = i_q;
  assign d_part_o = d_q;
  assign error_value_o = err_q;
  assign computed_o = computed_q;
  assign active_o = active_q;
endmodule

// ===== rtl/core/pid_controller_step.sv =====
// PID controller step: one item in, one result out per item.
// Commands and skipped updates pass ST_MUL_P to ST_DONE; a computed update
// runs ST_MUL_I to ST_INC_B, ST_DIV_D for the bit-serial divide by the elapsed
// time for the derivative term (skipped if that time is zero), ST_SUM, ST_DONE.
// Throughput: one item at a time; the next is accepted once the result is taken.
// Reset: asynchronous, active low; all but datapath scratch registers reset.
module pid_controller_step #(
  parameter int unsigned FRAC_BITS = pcs_pkg::FracBitsDefault,
  parameter bit DIRECT_ACTING = pcs_pkg::DirectActingDefault
) (
  input  logic clk_i,
  input  logic rst_ni,
  pcs_in_if.sink    in_if,
  pcs_out_if.source out_if,
  pcs_cfg_if.sink   cfg_if
);
  import pcs_pkg::*;
  `include "pid_controller_step_macros.svh"

  localparam logic signed [65:0] One = 66'sd1 <<< FRAC_BITS;

  cfg_t  cfg_q;
  ctrl_t ctrl;
  stat_t stat;
  logic  idle, done, in_fire, out_valid_q;

  assign in_fire = in_if.valid && in_if.ready;
  assign in_if.ready = idle && !out_valid_q;
  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain_p <= '0;
      cfg_q.gain_i <= '0;
      cfg_q.gain_d <= '0;
      cfg_q.output_min <= '0;
      cfg_q.output_max <= sat32(66'sd255 * One);
      cfg_q.integral_min <= sat32(-66'sd1000 * One);
      cfg_q.integral_max <= sat32(66'sd1000 * One);
      cfg_q.sample_period_ms <= 16'd100;
    end else if (cfg_if.valid) begin
      unique case (reg_e'(cfg_if.index))
        REG_GAIN_P:  cfg_q.gain_p <= cfg_if.data;
        REG_GAIN_I:  cfg_q.gain_i <= cfg_if.data;
        REG_GAIN_D:  cfg_q.gain_d <= cfg_if.data;
        REG_OUT_MIN: cfg_q.output_min <= cfg_if.data;
        REG_OUT_MAX: cfg_q.output_max <= cfg_if.data;
        REG_INT_MIN: cfg_q.integral_min <= cfg_if.data;
        REG_INT_MAX: cfg_q.integral_max <= cfg_if.data;
        REG_PERIOD:  cfg_q.sample_period_ms <= cfg_if.data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (done && !out_valid_q) begin
      out_valid_q <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  pcs_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_fire_i (in_fire),
    .out_free_i(!out_valid_q),
    .stat_i    (stat),
    .ctrl_o    (ctrl),
    .idle_o    (idle),
    .done_o    (done)
  );

  pcs_dp #(
    .FRAC_BITS    (FRAC_BITS),
    .DIRECT_ACTING(DIRECT_ACTING)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (ctrl),
    .cfg_i        (cfg_q),
    .command_i    (in_if.command),
    .measurement_i(in_if.measurement),
    .target_i     (in_if.target),
    .now_ms_i     (in_if.now_ms),
    .stat_o       (stat),
    .drive_o      (out_if.drive),
    .p_part_o     (out_if.p_part),
    .i_part_o     (out_if.i_part),
    .d_part_o     (out_if.d_part),
    .error_value_o(out_if.error_value),
    .computed_o   (out_if.computed),
    .active_o     (out_if.active)
  );

  assign out_if.valid = out_valid_q;

  `PCS_ASSERT_IMP(a_no_accept_while_out, clk_i, rst_ni, out_valid_q, !in_if.ready)
  `PCS_ASSERT_NEXT(a_load_leaves_idle, clk_i, rst_ni, in_fire, !idle)
  `PCS_ASSERT_IMP(a_result_only_when_done, clk_i, rst_ni, $rose(out_valid_q), $past(done))
endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for the PID controller step block.
`timescale 1ns / 100ps

module tb_top;
  import pcs_pkg::*;

  localparam int unsigned FRAC = FracBitsDefault;
  localparam bit DIRECT = DirectActingDefault;
  localparam logic signed [31:0] QMAX = 32'sh7fffffff;
  localparam logic signed [31:0] QMIN = 32'sh80000000;
  localparam logic signed [31:0] QONE = 32'sh00010000;
  localparam int unsigned RANDOM_PER_PHASE = 96;

  typedef logic [31:0] word_t;

  // Fields of one result item, in port order.
  typedef struct {
    word_t drive;
    word_t p_part;
    word_t i_part;
    word_t d_part;
    word_t error_value;
    logic  computed;
    logic  active;
  } pid_result_t;

  class pid_scoreboard;
    logic signed [31:0] kp, ki, kd, out_lo, out_hi, int_lo, int_hi;
    logic [15:0]        period;
    logic               enabled;
    logic signed [31:0] integ, prev_meas;
    logic [31:0]        last_ms;
    logic signed [31:0] drv, p_r, i_r, d_r, err_r;
    pid_result_t        expected_q[$];
    int                 errors;

    function new();
      kp = 0;
      ki = 0;
      kd = 0;
      out_lo = 0;
      out_hi = 255 * QONE;
      int_lo = -1000 * QONE;
      int_hi = 1000 * QONE;
      period = 16'd100;
      enabled = 1'b0;
      integ = 0;
      prev_meas = 0;
      last_ms = 0;
      errors = 0;
      clear_terms();
    endfunction

    function void clear_terms();
      drv = 0;
      p_r = 0;
      i_r = 0;
      d_r = 0;
      err_r = 0;
    endfunction

    function logic signed [31:0] saturate(input logic signed [65:0] v);
      if (v > 66'sd2147483647) return QMAX;
      if (v < -66'sd2147483648) return QMIN;
      return v[31:0];
    endfunction

    function logic signed [31:0] limit(input logic signed [31:0] v,
        input logic signed [31:0] lo, input logic signed [31:0] hi);
      if (v > hi) return hi;
      if (v < lo) return lo;
      return v;
    endfunction

    // Q product, floored back to Q by an arithmetic shift.
    function logic signed [31:0] qproduct(input logic signed [31:0] a,
        input logic signed [31:0] b);
      logic signed [63:0] a64, b64, prod;
      a64 = a;
      b64 = b;
      prod = a64 * b64;
      return saturate(prod >>> FRAC);
    endfunction

    function void write_reg(input reg_e idx, input word_t data);
      case (idx)
        REG_GAIN_P:  kp = data;
        REG_GAIN_I:  ki = data;
        REG_GAIN_D:  kd = data;
        REG_OUT_MIN: out_lo = data;
        REG_OUT_MAX: out_hi = data;
        REG_INT_MIN: int_lo = data;
        REG_INT_MAX: int_hi = data;
        REG_PERIOD:  period = data[15:0];
        default: ;
      endcase
    endfunction

    function void note_input(input cmd_e cmd, input logic signed [31:0] meas,
        input logic signed [31:0] tgt, input word_t now);
      logic [31:0]        dt;
      logic signed [63:0] dt64, k64, inc, m64, d64;
      logic signed [65:0] wide;
      logic signed [31:0] err, p, kie, acc, d, diff, m, sum;
      pid_result_t        r;
      logic               did;
      did = 1'b0;
      case (cmd)
        CMD_RESET: begin
          integ = 0;
          prev_meas = 0;
          last_ms = now;
          clear_terms();
        end
        CMD_ENABLE: begin
          enabled = 1'b1;
          last_ms = now;
        end
        CMD_DISABLE: begin
          enabled = 1'b0;
          drv = 0;
        end
        default: begin
          if (!enabled) begin
            clear_terms();
          end else begin
            dt = now - last_ms;
            if (dt >= {16'd0, period}) begin
              dt64 = $signed({32'd0, dt});
              wide = 66'(tgt) - 66'(meas);
              err = saturate(wide);
              p = qproduct(kp, err);
              kie = qproduct(ki, err);
              k64 = kie;
              inc = (k64 * dt64) / 64'sd1000;
              wide = 66'(integ) + 66'(inc);
              acc = limit(saturate(wide), int_lo, int_hi);
              integ = acc;
              d = 0;
              if (dt != 0) begin
                wide = 66'(meas) - 66'(prev_meas);
                diff = saturate(wide);
                m = qproduct(kd, diff);
                m64 = m;
                d64 = (m64 * 64'sd1000) / dt64;
                d = saturate(66'(d64));
              end
              wide = 66'(p) + 66'(acc) - 66'(d);
              sum = saturate(wide);
              if (!DIRECT) begin
                sum = saturate(-66'(sum));
                p = saturate(-66'(p));
                acc = saturate(-66'(acc));
                d = saturate(-66'(d));
              end
              drv = limit(sum, out_lo, out_hi);
              p_r = p;
              i_r = acc;
              d_r = d;
              err_r = err;
              prev_meas = meas;
              last_ms = now;
              did = 1'b1;
            end
          end
        end
      endcase
      r.drive = drv;
      r.p_part = p_r;
      r.i_part = i_r;
      r.d_part = d_r;
      r.error_value = err_r;
      r.computed = did;
      r.active = enabled;
      expected_q.push_back(r);
    endfunction

    function void check_result(input pid_result_t got);
      pid_result_t want;
      word_t       w[7], g[7];
      string       names[7];
      if (expected_q.size() == 0) begin
        $display("%0t: result item with nothing expected", $time);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      names = '{"drive", "p_part", "i_part", "d_part", "error_value", "computed", "active"};
      w = '{want.drive, want.p_part, want.i_part, want.d_part, want.error_value,
            32'(want.computed), 32'(want.active)};
      g = '{got.drive, got.p_part, got.i_part, got.d_part, got.error_value,
            32'(got.computed), 32'(got.active)};
      foreach (w[k]) begin
        if (w[k] !== g[k]) begin
          $display("%0t: %s expected %h actual %h", $time, names[k], w[k], g[k]);
          errors++;
        end
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  logic [31:0] now_t = 32'd0;
  logic [15:0] cur_period = 16'd100;
  pid_scoreboard sb = new();

  pcs_in_if  in_if  (clk_i);
  pcs_out_if out_if (clk_i);
  pcs_cfg_if cfg_if (clk_i);

  pid_controller_step dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_if),
    .out_if (out_if),
    .cfg_if (cfg_if)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(negedge clk_i) begin
    out_if.ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  always @(posedge clk_i) begin
    pid_result_t got;
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        sb.note_input(cmd_e'(in_if.command), in_if.measurement, in_if.target, in_if.now_ms);
      end
      if (out_if.valid && out_if.ready) begin
        got.drive = out_if.drive;
        got.p_part = out_if.p_part;
        got.i_part = out_if.i_part;
        got.d_part = out_if.d_part;
        got.error_value = out_if.error_value;
        got.computed = out_if.computed;
        got.active = out_if.active;
        sb.check_result(got);
      end
      if (cfg_if.valid && cfg_if.ready) begin
        sb.write_reg(reg_e'(cfg_if.index), cfg_if.data);
      end
    end
  end

  task automatic send_item(input cmd_e cmd, input word_t meas, input word_t tgt,
      input word_t now);
    if ($urandom_range(99) < tx_idle_pct) begin
      @(negedge clk_i);
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end else begin
      @(negedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.command <= cmd;
    in_if.measurement <= meas;
    in_if.target <= tgt;
    in_if.now_ms <= now;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  // Stops the sender and waits until every expected result item has come.
  task automatic drain();
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_cfg(input reg_e idx, input word_t data);
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= data;
    do @(posedge clk_i); while (!cfg_if.ready);
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
    if (idx == REG_PERIOD) cur_period = data[15:0];
  endtask

  function automatic word_t rand_signed(input int unsigned span);
    return word_t'($urandom_range(2 * span) - span);
  endfunction

  function automatic word_t rand_value();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 50) return rand_signed(6553600);
    if (pick < 80) return $urandom;
    case ($urandom_range(4))
      0: return QMAX;
      1: return QMIN;
      2: return 32'd0;
      3: return 32'hffffffff;
      default: return 32'd1;
    endcase
  endfunction

  // Timestamp step: mostly past the period, some early, some far jumps that wrap.
  function automatic word_t next_time();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 65) return now_t + cur_period + $urandom_range(20);
    if (pick < 85) return (cur_period == 0) ? now_t : now_t + $urandom_range(cur_period - 1);
    return $urandom;
  endfunction

  task automatic apply_settings(input int unsigned k);
    word_t lo, hi;
    drain();
    case (k)
      0: begin
        write_cfg(REG_GAIN_P, QONE);
        write_cfg(REG_GAIN_I, QONE / 2);
        write_cfg(REG_GAIN_D, QONE / 4);
        write_cfg(REG_OUT_MIN, 32'd0);
        write_cfg(REG_OUT_MAX, 255 * QONE);
        write_cfg(REG_INT_MIN, -1000 * QONE);
        write_cfg(REG_INT_MAX, 1000 * QONE);
        write_cfg(REG_PERIOD, 32'd100);
      end
      1: begin
        write_cfg(REG_GAIN_P, $urandom);
        write_cfg(REG_GAIN_I, $urandom);
        write_cfg(REG_GAIN_D, $urandom);
        write_cfg(REG_OUT_MIN, QMIN);
        write_cfg(REG_OUT_MAX, QMAX);
        write_cfg(REG_INT_MIN, QMIN);
        write_cfg(REG_INT_MAX, QMAX);
        write_cfg(REG_PERIOD, 32'd1);
      end
      2: begin
        // Crossed limits with a zero period.
        write_cfg(REG_GAIN_P, rand_signed(8 * QONE));
        write_cfg(REG_GAIN_I, rand_signed(8 * QONE));
        write_cfg(REG_GAIN_D, rand_signed(8 * QONE));
        write_cfg(REG_OUT_MIN, 100 * QONE);
        write_cfg(REG_OUT_MAX, -100 * QONE);
        write_cfg(REG_INT_MIN, 10 * QONE);
        write_cfg(REG_INT_MAX, -10 * QONE);
        write_cfg(REG_PERIOD, 32'd0);
      end
      3: begin
        write_cfg(REG_GAIN_P, QMAX);
        write_cfg(REG_GAIN_I, QMIN);
        write_cfg(REG_GAIN_D, QMAX);
        write_cfg(REG_OUT_MIN, QMIN);
        write_cfg(REG_OUT_MAX, QMAX);
        write_cfg(REG_INT_MIN, QMIN);
        write_cfg(REG_INT_MAX, QMAX);
        write_cfg(REG_PERIOD, 32'hffff);
      end
      4: begin
        write_cfg(REG_GAIN_P, QMIN);
        write_cfg(REG_GAIN_I, QMAX);
        write_cfg(REG_GAIN_D, QMIN);
        write_cfg(REG_OUT_MIN, 32'd0);
        write_cfg(REG_OUT_MAX, 255 * QONE);
        write_cfg(REG_INT_MIN, -1000 * QONE);
        write_cfg(REG_INT_MAX, 1000 * QONE);
        write_cfg(REG_PERIOD, 32'd50);
      end
      default: begin
        lo = rand_signed(2000 * QONE);
        hi = lo + $urandom_range(2000 * QONE);
        write_cfg(REG_GAIN_P, rand_signed(4 * QONE));
        write_cfg(REG_GAIN_I, rand_signed(4 * QONE));
        write_cfg(REG_GAIN_D, rand_signed(QONE));
        write_cfg(REG_OUT_MIN, lo);
        write_cfg(REG_OUT_MAX, hi);
        write_cfg(REG_INT_MIN, -hi);
        write_cfg(REG_INT_MAX, -lo);
        write_cfg(REG_PERIOD, $urandom_range(1, 300));
      end
    endcase
    // Gain changes are followed by a state reset.
    send_item(CMD_RESET, rand_value(), rand_value(), now_t);
    send_item(CMD_ENABLE, rand_value(), rand_value(), now_t);
  endtask

  task automatic random_phase();
    int unsigned pick;
    cmd_e        cmd;
    repeat (RANDOM_PER_PHASE) begin
      pick = $urandom_range(99);
      if (pick < 72) cmd = CMD_UPDATE;
      else if (pick < 81) cmd = CMD_RESET;
      else if (pick < 91) cmd = CMD_ENABLE;
      else cmd = CMD_DISABLE;
      now_t = next_time();
      send_item(cmd, rand_value(), rand_value(), now_t);
      if ($urandom_range(99) < 2) drain();
    end
  endtask

  initial begin
    in_if.valid = 1'b0;
    in_if.command = CMD_UPDATE;
    in_if.measurement = '0;
    in_if.target = '0;
    in_if.now_ms = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = REG_GAIN_P;
    cfg_if.data = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);

    // Directed part with reset defaults, then with Kp = 1, Ki = 1/2 and Kd = 1/4.
    send_item(CMD_UPDATE, 32'd5, 32'd9, 32'd500);
    send_item(CMD_ENABLE, 32'd0, 32'd0, 32'd1000);
    send_item(CMD_UPDATE, QONE, 2 * QONE, 32'd1050);
    send_item(CMD_UPDATE, QONE, 2 * QONE, 32'd1100);
    apply_settings(0);
    now_t = 32'd2000;
    send_item(CMD_UPDATE, QONE, 10 * QONE, 32'd2100);
    send_item(CMD_UPDATE, 3 * QONE, 10 * QONE, 32'd2199);
    send_item(CMD_UPDATE, 3 * QONE, 10 * QONE, 32'd2300);
    send_item(CMD_UPDATE, QMAX, QMIN, 32'd2400);
    send_item(CMD_UPDATE, QMIN, QMAX, 32'd2500);
    send_item(CMD_UPDATE, QMIN, QMIN, 32'd2600);
    send_item(CMD_UPDATE, -500 * QONE, 500 * QONE, 32'hffffffd0);
    send_item(CMD_UPDATE, -500 * QONE, 500 * QONE, 32'd60);
    send_item(CMD_DISABLE, 32'd0, 32'd0, 32'd100);
    send_item(CMD_UPDATE, QONE, QONE, 32'd300);
    send_item(CMD_ENABLE, 32'd0, 32'd0, 32'd400);
    send_item(CMD_UPDATE, 7 * QONE, QONE, 32'd600);
    send_item(CMD_RESET, 32'd0, 32'd0, 32'd700);
    send_item(CMD_UPDATE, 7 * QONE, QONE, 32'd900);
    now_t = 32'd900;

    for (int unsigned ph = 0; ph < 6; ph++) begin
      if (ph < 2) begin
        tx_idle_pct = 7;
        rx_idle_pct = 74;
      end else if (ph < 4) begin
        tx_idle_pct = 74;
        rx_idle_pct = 7;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      apply_settings((ph + 1) % 6);
      random_phase();
    end

    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/pcs_pkg.sv
rtl/core/pcs_if.sv
rtl/core/pcs_ctrl.sv
rtl/core/pcs_div.sv
rtl/core/pcs_dp.sv
rtl/core/pid_controller_step.sv
dv/tb_top.sv
